// ===== design/assert_macros.svh =====
// Assertion macros shared by the ring store modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mcrs_pkg.sv =====
// Types, widths and codes shared by the ring store modules.
package mcrs_pkg;

   localparam int NUM_CHAINS   = 8;
   localparam int MAX_ELEMENTS = 32;
   localparam int DATA_WIDTH   = 32;

   localparam int CHAIN_W     = 3;
   localparam int POS_W       = 5;
   localparam int EPC_W       = 6;
   localparam int CIU_W       = 4;
   localparam int ADDR_W      = 8;
   localparam int BASE_W      = 9;
   localparam int CNT_W       = 6;
   localparam int STATUS_W    = 2;
   localparam int OP_W        = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 6;
   localparam int REM_W       = POS_W + 1;
   localparam int MOD_CNT_W   = 3;
   localparam int STORE_DEPTH = 256;

   localparam logic [CIU_W-1:0]     CHAINS_RESET = CIU_W'(NUM_CHAINS);
   localparam logic [EPC_W-1:0]     ELEMS_RESET  = EPC_W'(MAX_ELEMENTS);
   localparam logic [MOD_CNT_W-1:0] MOD_LAST     = MOD_CNT_W'(EPC_W - 1);

   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 3'd3;
   localparam logic [OP_W-1:0] OP_UPDATE    = 3'd4;
   localparam logic [OP_W-1:0] OP_READ      = 3'd5;
   localparam logic [OP_W-1:0] OP_COUNT     = 3'd6;
   localparam logic [OP_W-1:0] OP_EMIT      = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_CHAINS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ELEMENTS      = 1'b1;

   typedef struct packed {
      logic                 accept;
      logic                 decode;
      logic                 single;
      logic                 mod_step;
      logic [MOD_CNT_W-1:0] mod_shift;
      logic                 access;
      logic                 readout;
      logic                 emit_step;
   } mcrs_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            active;
      logic            empty;
      logic            one_elem;
      logic            pair_last;
   } mcrs_stat_type;

endpackage

// ===== design/mcrs_dp.sv =====
// Datapath: chain pointers, element store, remainder unit and result registers.
`include "assert_macros.svh"

module mcrs_dp
   import mcrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  mcrs_cmd_type          cmd,
   output mcrs_stat_type         stat,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CHAIN_W-1:0]    req_chain,
   input  logic [POS_W-1:0]      req_element_index,
   input  logic [DATA_WIDTH-1:0] req_element_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_data,
   output logic [CNT_W-1:0]      rsp_element_count,
   output logic [BASE_W-1:0]     rsp_earlier_base,
   output logic [BASE_W-1:0]     rsp_later_base,
   output logic                  rsp_pair_valid,
   output logic                  rsp_last
);

   logic [CIU_W-1:0]      ciu_ff, ciu_in;
   logic [EPC_W-1:0]      epc_ff, epc_in;
   logic [POS_W-1:0]      head_ff [NUM_CHAINS];
   logic [POS_W-1:0]      head_in [NUM_CHAINS];
   logic [POS_W-1:0]      tail_ff [NUM_CHAINS];
   logic [POS_W-1:0]      tail_in [NUM_CHAINS];
   logic [NUM_CHAINS-1:0] empty_ff, empty_in;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [CHAIN_W-1:0]    chain_ff, chain_in;
   logic [POS_W-1:0]      off_ff, off_in;
   logic [DATA_WIDTH-1:0] data_ff, data_in;
   logic [ADDR_W-1:0]     start_ff, start_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [POS_W-1:0]      prev_ff, prev_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_read_data_ff, rsp_read_data_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic [BASE_W-1:0]     rsp_earlier_base_ff, rsp_earlier_base_in;
   logic [BASE_W-1:0]     rsp_later_base_ff, rsp_later_base_in;
   logic                  rsp_pair_valid_ff, rsp_pair_valid_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [DATA_WIDTH-1:0] store_mem [STORE_DEPTH];
   logic                  mem_we, mem_re;
   logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   logic [POS_W-1:0]         cur_h, cur_t, back_h, back_t, epc_m1, next_pos;
   logic                     cur_e, active;
   logic [EPC_W-1:0]         epc_dec, succ;
   logic [CHAIN_W+EPC_W-1:0] start_prod;
   logic [CNT_W:0]           count_wide;
   logic [REM_W+EPC_W-1:0]   div_shift, rem_ext;
   logic [ADDR_W-1:0]        rw_addr, earlier_addr, later_addr;
   logic [CIU_W-1:0]         ciu_raw;
   logic [EPC_W-1:0]         epc_raw;

   assign cur_h   = head_ff[chain_ff];
   assign cur_t   = tail_ff[chain_ff];
   assign cur_e   = empty_ff[chain_ff];
   assign active  = {1'b0, chain_ff} < ciu_ff;
   assign epc_dec = epc_ff - EPC_W'(1);
   assign epc_m1  = epc_dec[POS_W-1:0];
   assign back_h  = (cur_h == '0) ? epc_m1 : cur_h - POS_W'(1);
   assign back_t  = (cur_t == '0) ? epc_m1 : cur_t - POS_W'(1);
   assign succ    = {1'b0, prev_ff} + EPC_W'(1);
   assign next_pos = (succ == epc_ff) ? '0 : succ[POS_W-1:0];

   assign start_prod   = CHAIN_W'(req_chain) * epc_ff;
   assign count_wide   = (cur_t < cur_h)
                         ? {2'b00, cur_t} + {1'b0, epc_ff} + (CNT_W+1)'(1) - {2'b00, cur_h}
                         : {2'b00, cur_t} - {2'b00, cur_h} + (CNT_W+1)'(1);
   assign div_shift    = {{REM_W{1'b0}}, epc_ff} << cmd.mod_shift;
   assign rem_ext      = {{EPC_W{1'b0}}, rem_ff};
   assign rw_addr      = start_ff + ADDR_W'(rem_ff[POS_W-1:0]);
   assign earlier_addr = start_ff + ADDR_W'(prev_ff);
   assign later_addr   = start_ff + ADDR_W'(next_pos);
   assign ciu_raw      = csr_write_data[CIU_W-1:0];
   assign epc_raw      = csr_write_data[EPC_W-1:0];

   assign stat.op        = op_ff;
   assign stat.active    = active;
   assign stat.empty     = cur_e;
   assign stat.one_elem  = (cur_h == cur_t);
   assign stat.pair_last = (next_pos == cur_t);

   always_comb begin
      ciu_in   = ciu_ff;
      epc_in   = epc_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      op_in    = op_ff;
      chain_in = chain_ff;
      off_in   = off_ff;
      data_in  = data_ff;
      start_in = start_ff;
      rem_in   = rem_ff;
      prev_in  = prev_ff;

      rsp_strobe_in       = 1'b0;
      rsp_status_in       = rsp_status_ff;
      rsp_read_data_in    = rsp_read_data_ff;
      rsp_count_in        = rsp_count_ff;
      rsp_earlier_base_in = rsp_earlier_base_ff;
      rsp_later_base_in   = rsp_later_base_ff;
      rsp_pair_valid_in   = rsp_pair_valid_ff;
      rsp_last_in         = rsp_last_ff;

      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = rw_addr;
      mem_raddr = rw_addr;
      mem_wdata = data_ff;

      if (csr_write_enable) begin
         if (csr_index == REG_CHAINS_IN_USE) begin
            if (ciu_raw == '0) begin
               ciu_in = CIU_W'(1);
            end else if (ciu_raw > CHAINS_RESET) begin
               ciu_in = CHAINS_RESET;
            end else begin
               ciu_in = ciu_raw;
            end
         end else begin
            if (epc_raw == '0) begin
               epc_in = EPC_W'(1);
            end else if (epc_raw > ELEMS_RESET) begin
               epc_in = ELEMS_RESET;
            end else begin
               epc_in = epc_raw;
            end
         end
         for (int i = 0; i < NUM_CHAINS; i++) begin
            head_in[i] = '0;
            tail_in[i] = '0;
         end
         empty_in = '1;
      end else begin
         if (cmd.accept) begin
            op_in    = req_operation;
            chain_in = req_chain;
            off_in   = req_element_index;
            data_in  = req_element_data;
            start_in = start_prod[ADDR_W-1:0];
         end

         if (cmd.decode) begin
            rem_in  = {1'b0, cur_h} + {1'b0, off_ff};
            prev_in = cur_h;
         end

         // one-result commands, decided and finished in the decode cycle
         if (cmd.single) begin
            rsp_strobe_in       = 1'b1;
            rsp_last_in         = 1'b1;
            rsp_status_in       = ST_OK;
            rsp_read_data_in    = '0;
            rsp_count_in        = '0;
            rsp_earlier_base_in = '0;
            rsp_later_base_in   = '0;
            rsp_pair_valid_in   = 1'b0;
            if (op_ff == OP_CLEAR_ALL) begin
               for (int i = 0; i < NUM_CHAINS; i++) begin
                  head_in[i] = '0;
                  tail_in[i] = '0;
               end
               empty_in = '1;
            end else if (!active) begin
               rsp_status_in = ST_RANGE;
            end else begin
               case (op_ff) inside
                  OP_ADD: begin
                     empty_in[chain_ff] = 1'b0;
                     if (cur_e) begin
                        head_in[chain_ff] = epc_m1;
                        tail_in[chain_ff] = epc_m1;
                        mem_waddr = start_ff + ADDR_W'(epc_m1);
                     end else begin
                        head_in[chain_ff] = back_h;
                        if (back_h == cur_t) begin
                           tail_in[chain_ff] = back_t;
                        end
                        mem_waddr = start_ff + ADDR_W'(back_h);
                     end
                     mem_we = 1'b1;
                  end
                  OP_REMOVE: begin
                     if (cur_e) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (cur_t == cur_h) begin
                        empty_in[chain_ff] = 1'b1;
                        head_in[chain_ff]  = '0;
                        tail_in[chain_ff]  = '0;
                     end else begin
                        tail_in[chain_ff] = back_t;
                     end
                  end
                  OP_CLEAR: begin
                     empty_in[chain_ff] = 1'b1;
                     head_in[chain_ff]  = '0;
                     tail_in[chain_ff]  = '0;
                  end
                  OP_UPDATE, OP_READ: begin
                     if (cur_e) begin
                        rsp_status_in = ST_EMPTY;
                     end
                  end
                  OP_COUNT: begin
                     if (!cur_e) begin
                        rsp_count_in = count_wide[CNT_W-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // restoring remainder: one shifted compare and subtract per cycle
         if (cmd.mod_step) begin
            if (rem_ext >= div_shift) begin
               rem_in = rem_ff - div_shift[REM_W-1:0];
            end
         end

         if (cmd.access) begin
            if (op_ff == OP_UPDATE) begin
               mem_we              = 1'b1;
               rsp_strobe_in       = 1'b1;
               rsp_last_in         = 1'b1;
               rsp_status_in       = ST_OK;
               rsp_read_data_in    = '0;
               rsp_count_in        = '0;
               rsp_earlier_base_in = '0;
               rsp_later_base_in   = '0;
               rsp_pair_valid_in   = 1'b0;
            end else begin
               mem_re = 1'b1;
            end
         end

         if (cmd.readout) begin
            rsp_strobe_in       = 1'b1;
            rsp_last_in         = 1'b1;
            rsp_status_in       = ST_OK;
            rsp_read_data_in    = rd_data_ff;
            rsp_count_in        = '0;
            rsp_earlier_base_in = '0;
            rsp_later_base_in   = '0;
            rsp_pair_valid_in   = 1'b0;
         end

         if (cmd.emit_step) begin
            rsp_strobe_in       = 1'b1;
            rsp_last_in         = stat.pair_last;
            rsp_status_in       = ST_OK;
            rsp_read_data_in    = '0;
            rsp_count_in        = '0;
            rsp_earlier_base_in = {earlier_addr, 1'b0};
            rsp_later_base_in   = {later_addr, 1'b0};
            rsp_pair_valid_in   = 1'b1;
            prev_in             = next_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ciu_ff        <= CHAINS_RESET;
         epc_ff        <= ELEMS_RESET;
         empty_ff      <= '1;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < NUM_CHAINS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         ciu_ff        <= ciu_in;
         epc_ff        <= epc_in;
         empty_ff      <= empty_in;
         rsp_strobe_ff <= rsp_strobe_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff               <= op_in;
      chain_ff            <= chain_in;
      off_ff              <= off_in;
      data_ff             <= data_in;
      start_ff            <= start_in;
      rem_ff              <= rem_in;
      prev_ff             <= prev_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_read_data_ff    <= rsp_read_data_in;
      rsp_count_ff        <= rsp_count_in;
      rsp_earlier_base_ff <= rsp_earlier_base_in;
      rsp_later_base_ff   <= rsp_later_base_in;
      rsp_pair_valid_ff   <= rsp_pair_valid_in;
      rsp_last_ff         <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_raddr];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_earlier_base  = rsp_earlier_base_ff;
   assign rsp_later_base    = rsp_later_base_ff;
   assign rsp_pair_valid    = rsp_pair_valid_ff;
   assign rsp_last          = rsp_last_ff;

   `ASSERT_NEXT(a_single_gives_last, clock, reset, cmd.single, rsp_strobe_ff && rsp_last_ff, "one-result command did not give a final transaction")
   `ASSERT_IMPL(a_pair_distinct, clock, reset, rsp_strobe_ff && rsp_pair_valid_ff, rsp_status_ff == ST_OK && rsp_earlier_base_ff != rsp_later_base_ff, "pair transaction with bad status or equal bases")

endmodule

// ===== design/mcrs_ctrl.sv =====
// Controller: sequences decode, remainder steps, store access and pair walk.
`include "assert_macros.svh"

module mcrs_ctrl
   import mcrs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  mcrs_stat_type stat,
   output mcrs_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECODE  = 3'd1;
   localparam logic [2:0] S_MOD     = 3'd2;
   localparam logic [2:0] S_ACCESS  = 3'd3;
   localparam logic [2:0] S_READOUT = 3'd4;
   localparam logic [2:0] S_EMIT    = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic [MOD_CNT_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic                 is_rw;

   assign is_rw = (stat.op == OP_UPDATE) || (stat.op == OP_READ);
   assign busy  = (state_ff != S_IDLE);

   always_comb begin
      cmd           = '0;
      cmd.mod_shift = mod_cnt_ff;
      state_in      = state_ff;
      mod_cnt_in    = mod_cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            mod_cnt_in = MOD_LAST;
            if (stat.op == OP_CLEAR_ALL || !stat.active) begin
               cmd.single = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.op == OP_EMIT) begin
               if (stat.empty || stat.one_elem) begin
                  cmd.single = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  state_in = S_EMIT;
               end
            end else if (is_rw && !stat.empty) begin
               state_in = S_MOD;
            end else begin
               cmd.single = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (mod_cnt_ff == '0) begin
               state_in = S_ACCESS;
            end else begin
               mod_cnt_in = mod_cnt_ff - MOD_CNT_W'(1);
            end
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = (stat.op == OP_READ) ? S_READOUT : S_IDLE;
         end
         S_READOUT: begin
            cmd.readout = 1'b1;
            state_in    = S_IDLE;
         end
         S_EMIT: begin
            cmd.emit_step = 1'b1;
            if (stat.pair_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mod_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mod_cnt_ff <= mod_cnt_in;
      end
   end

   `ASSERT_IMPL(a_emit_op, clock, reset, state_ff == S_EMIT, stat.op == OP_EMIT, "pair walk running for a command other than emit pairs")
   `ASSERT_IMPL(a_mod_op, clock, reset, state_ff == S_MOD || state_ff == S_ACCESS, stat.op == OP_UPDATE || stat.op == OP_READ, "store access for a command other than update or read")

endmodule

// ===== design/multi_chain_ring_store.sv =====
// Top level of the multi-chain ring store: controller plus datapath.
// A transaction is taken when start is high and busy is low; busy then stays high until
// the command's last result is issued. Add, remove, clear, clear all, count, emit pairs
// on a chain with fewer than two elements, inactive chains and empty-chain errors are
// finished in decode, which registers the result. For update and read the
// offset from the head is reduced modulo the chain capacity by a 6-step shift-subtract
// remainder unit, followed by one access to the single-port 256 x 32 element store and,
// for read, a readout step for its registered read data. Emit pairs walks its pairs
// one pair per cycle. Each result is held for exactly one cycle under rsp_strobe
// and cannot be stalled; rsp_last marks the final result of a transaction. Configuration
// writes must only be made while idle and empty every chain. Store entries come out of
// reset unwritten; no clearing pass is done.
module multi_chain_ring_store
   import mcrs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [CHAIN_W-1:0]    req_chain,
   input  logic [POS_W-1:0]      req_element_index,
   input  logic [DATA_WIDTH-1:0] req_element_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_read_data,
   output logic [CNT_W-1:0]      rsp_element_count,
   output logic [BASE_W-1:0]     rsp_earlier_base,
   output logic [BASE_W-1:0]     rsp_later_base,
   output logic                  rsp_pair_valid,
   output logic                  rsp_last
);

   mcrs_cmd_type  cmd;
   mcrs_stat_type stat;

   mcrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   mcrs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_operation     (req_operation),
      .req_chain         (req_chain),
      .req_element_index (req_element_index),
      .req_element_data  (req_element_data),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_element_count (rsp_element_count),
      .rsp_earlier_base  (rsp_earlier_base),
      .rsp_later_base    (rsp_later_base),
      .rsp_pair_valid    (rsp_pair_valid),
      .rsp_last          (rsp_last)
   );

endmodule
